// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the point decimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while arst_n is low.
`define UDEC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("uniform_point_decimator: assertion failed");

// Check that cons holds in the cycle after ante.
`define UDEC_ASSERT_NEXT(lbl, ante, cons) \
	`UDEC_ASSERT(lbl, (ante) |=> (cons))

`endif

// ----- hdl/udec_pkg.sv -----
// Types and constants shared by the point decimator modules.
package udec_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned MAXP_W  = 16;
	localparam int unsigned SCALE_W = 48;

	localparam logic [MAXP_W-1:0] MAXP_RESET = 16'd512;
	localparam logic [MAXP_W-1:0] MAXP_FLOOR = 16'd2;

	typedef struct packed {
		logic [COORD_W-1:0] lon;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] alt;
		logic [COUNT_W-1:0] seg_count;
		logic               seg_first;
	} item_t;

	typedef struct packed {
		logic               keep;
		logic               last;
		logic [COUNT_W-1:0] index;
	} decision_t;

endpackage

// ----- hdl/uniform_point_decimator.sv -----
// Top level of the uniform point decimator: config register, stages and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | lon_bits lat_bits alt_bits seg_count seg_first
//  out      | out_valid / out_ready  | out_lon out_lat out_alt out_index seg_last
//  cfg      | cfg_we (no wait)       | cfg_wdata -> max_points
//
// One point per cycle unless the out side stalls; a kept point passes the input register
// and then the result register before it shows on out_valid. The 32x16 position multiply
// and 48-bit compare form the one stage between the input register and the result register.
// Reset clears the segment state and loads max_points with 512.
// A stalled out side holds the result and the point behind it, kept or dropped.
module uniform_point_decimator import udec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] lon_bits,
	input  logic [COORD_W-1:0] lat_bits,
	input  logic [COORD_W-1:0] alt_bits,
	input  logic [COUNT_W-1:0] seg_count,
	input  logic               seg_first,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] out_lon,
	output logic [COORD_W-1:0] out_lat,
	output logic [COORD_W-1:0] out_alt,
	output logic [COUNT_W-1:0] out_index,
	output logic               seg_last,
	input  logic               cfg_we,
	input  logic [MAXP_W-1:0]  cfg_wdata
);

	logic [MAXP_W-1:0]  max_points_q;
	logic [MAXP_W-1:0]  max_eff;
	item_t              in_item;
	item_t              item_s1;
	logic               valid_s1;
	logic               advance;
	decision_t          dec;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_lon_q;
	logic [COORD_W-1:0] out_lat_q;
	logic [COORD_W-1:0] out_alt_q;
	logic [COUNT_W-1:0] out_index_q;
	logic               seg_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_points_q <= MAXP_RESET;
		end else if (cfg_we) begin
			max_points_q <= cfg_wdata;
		end
	end

	// Anything below two keeps both ends.
	assign max_eff = (max_points_q < MAXP_FLOOR) ? MAXP_FLOOR : max_points_q;

	assign in_item.lon       = lon_bits;
	assign in_item.lat       = lat_bits;
	assign in_item.alt       = alt_bits;
	assign in_item.seg_count = seg_count;
	assign in_item.seg_first = seg_first;

	udec_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Advance whenever the result slot is empty or draining this cycle.
	assign advance = valid_s1 && (!out_valid_q || out_ready);

	udec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.max_eff (max_eff),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= dec.keep;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.keep) begin
			out_lon_q   <= item_s1.lon;
			out_lat_q   <= item_s1.lat;
			out_alt_q   <= item_s1.alt;
			out_index_q <= dec.index;
			seg_last_q  <= dec.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_lon   = out_lon_q;
	assign out_lat   = out_lat_q;
	assign out_alt   = out_alt_q;
	assign out_index = out_index_q;
	assign seg_last  = seg_last_q;

endmodule

// ----- hdl/udec_in_stage.sv -----
// Input register stage: captures one point beat and hands it to the keep logic.
module udec_in_stage import udec_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic valid_q;

	// Take a new beat whenever the register is empty or the held one leaves in the same cycle.
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hdl/udec_core.sv -----
// Segment state and the keep test for each point.
module udec_core import udec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  item_t             item_s1,
	input  logic [MAXP_W-1:0] max_eff,
	output decision_t         dec
);

	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] pidx_q;
	logic [COUNT_W-1:0] kept_q;
	logic [SCALE_W-1:0] thr_q;
	logic               thin_q;

	logic [COUNT_W-1:0] total_c;
	logic [COUNT_W-1:0] pidx_c;
	logic [COUNT_W-1:0] kept_c;
	logic [SCALE_W-1:0] thr_c;
	logic               thin_c;
	logic [COUNT_W-1:0] total_m1;
	logic [MAXP_W-1:0]  max_m1;
	logic [SCALE_W-1:0] pos;
	logic               in_seg;
	logic               last;
	logic               keep;

	// A first point restarts the segment before its own test.
	always_comb begin
		if (item_s1.seg_first) begin
			total_c = item_s1.seg_count;
			pidx_c  = '0;
			kept_c  = '0;
			thr_c   = '0;
			thin_c  = item_s1.seg_count > COUNT_W'(max_eff);
		end else begin
			total_c = total_q;
			pidx_c  = pidx_q;
			kept_c  = kept_q;
			thr_c   = thr_q;
			thin_c  = thin_q;
		end
	end

	assign total_m1 = total_c - COUNT_W'(1);
	assign max_m1   = max_eff - MAXP_W'(1);
	assign pos      = SCALE_W'(pidx_c) * SCALE_W'(max_m1);
	assign in_seg   = pidx_c < total_c;
	assign last     = pidx_c == total_m1;
	assign keep     = in_seg && (!thin_c || last || (pos >= thr_c));

	assign dec.keep  = keep;
	assign dec.last  = last;
	assign dec.index = kept_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pidx_q  <= '0;
			kept_q  <= '0;
			thr_q   <= '0;
			thin_q  <= 1'b0;
		end else if (advance) begin
			total_q <= total_c;
			thin_q  <= thin_c;
			pidx_q  <= in_seg ? pidx_c + COUNT_W'(1) : pidx_c;
			// thr tracks kept*(count-1) modulo the scale width
			if (keep) begin
				kept_q <= kept_c + COUNT_W'(1);
				thr_q  <= thr_c + SCALE_W'(total_m1);
			end else begin
				kept_q <= kept_c;
				thr_q  <= thr_c;
			end
		end
	end

endmodule

// ----- hdl/udec_checker.sv -----
// Port-level checks for the uniform point decimator, bound to the top level.
`include "assert_macros.svh"

module udec_checker import udec_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COORD_W-1:0] out_lon,
	input logic [COORD_W-1:0] out_lat,
	input logic [COORD_W-1:0] out_alt,
	input logic [COUNT_W-1:0] out_index,
	input logic               seg_last
);

	// A stalled result beat holds.
	`UDEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lon) && $stable(out_lat) && $stable(out_alt) && $stable(out_index) && $stable(seg_last))

	// Nothing is shown in the first cycle out of reset.
	`UDEC_ASSERT(a_reset_empty, $rose(arst_n) |-> !out_valid)

	// A fresh result traces back to an input beat that passed through the input register.
	`UDEC_ASSERT(a_out_source, (out_valid && !$past(out_valid)) |-> $past(in_valid && in_ready, 2))

	// After the last beat of a segment the next result opens a new one.
	`UDEC_ASSERT_NEXT(a_seg_restart, out_valid && out_ready && seg_last, !out_valid || (out_index == '0))

endmodule

bind uniform_point_decimator udec_checker u_udec_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the uniform point decimator: directed plan, then random segments.
`timescale 1ns / 1ps

module testbench;
	import udec_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_ITEMS   = 1200;
	localparam int SETTLE_WAIT  = 6;

	typedef enum {ROW_PREDICT, ROW_DROP, ROW_KEEP, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		item_t              pt;
		logic [COUNT_W-1:0] idx;
		logic               lst;
	} plan_row_t;

	typedef struct {
		logic [COORD_W-1:0] lon;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] alt;
		logic [COUNT_W-1:0] index;
		logic               last;
	} kept_point_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [COORD_W-1:0] lon_bits;
	logic [COORD_W-1:0] lat_bits;
	logic [COORD_W-1:0] alt_bits;
	logic [COUNT_W-1:0] seg_count;
	logic               seg_first;
	logic               out_valid;
	logic               out_ready;
	logic [COORD_W-1:0] out_lon;
	logic [COORD_W-1:0] out_lat;
	logic [COORD_W-1:0] out_alt;
	logic [COUNT_W-1:0] out_index;
	logic               seg_last;
	logic               cfg_we;
	logic [MAXP_W-1:0]  cfg_wdata;

	uniform_point_decimator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.lon_bits  (lon_bits),
		.lat_bits  (lat_bits),
		.alt_bits  (alt_bits),
		.seg_count (seg_count),
		.seg_first (seg_first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_lon   (out_lon),
		.out_lat   (out_lat),
		.out_alt   (out_alt),
		.out_index (out_index),
		.seg_last  (seg_last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// decimator state as predicted
	logic [MAXP_W-1:0]  max_pts;
	logic [COUNT_W-1:0] seg_total;
	logic [COUNT_W-1:0] seg_pos;
	logic [COUNT_W-1:0] seg_kept;
	logic               thinning;

	kept_point_t kept_q[$];
	plan_row_t   plan[$];
	int          errors;
	int          cycles;
	bit          quiet;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic bit predict_point(input item_t pt, output kept_point_t res);
		logic [31:0] m;
		logic [63:0] pos_scaled;
		logic [63:0] threshold;
		bit          keep;
		bit          at_end;
		m = (max_pts < MAXP_FLOOR) ? 32'(MAXP_FLOOR) : 32'(max_pts);
		res = '{default: '0};
		if (pt.seg_first) begin
			seg_total = pt.seg_count;
			seg_pos   = '0;
			seg_kept  = '0;
			thinning  = seg_total > m;
		end
		if (seg_pos >= seg_total)
			return 1'b0;
		at_end = (seg_pos == seg_total - 1);
		if (thinning) begin
			pos_scaled = (64'(seg_pos) * 64'(m - 1)) & 64'hFFFF_FFFF_FFFF;
			threshold  = (64'(seg_kept) * 64'(seg_total - 1)) & 64'hFFFF_FFFF_FFFF;
			keep = at_end || (pos_scaled >= threshold);
		end else begin
			keep = 1'b1;
		end
		seg_pos++;
		if (!keep)
			return 1'b0;
		res.lon   = pt.lon;
		res.lat   = pt.lat;
		res.alt   = pt.alt;
		res.index = seg_kept;
		res.last  = at_end;
		seg_kept++;
		return 1'b1;
	endfunction

	function automatic plan_row_t mk(input row_kind_t kind, input logic [31:0] lon,
			input logic [31:0] lat, input logic [31:0] alt, input logic [31:0] cnt,
			input logic first, input logic [31:0] idx, input logic lst);
		plan_row_t r;
		r.kind         = kind;
		r.pt.lon       = lon;
		r.pt.lat       = lat;
		r.pt.alt       = alt;
		r.pt.seg_count = cnt;
		r.pt.seg_first = first;
		r.idx          = idx;
		r.lst          = lst;
		return r;
	endfunction

	function automatic item_t rand_point(input logic first, input logic [31:0] cnt);
		item_t pt;
		pt.lon       = $urandom;
		pt.lat       = $urandom;
		pt.alt       = $urandom;
		pt.seg_count = cnt;
		pt.seg_first = first;
		return pt;
	endfunction

	task automatic send_point(input item_t pt, input row_kind_t kind,
			input logic [31:0] idx, input logic lst);
		kept_point_t res;
		bit          hit;
		if (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		lon_bits  <= pt.lon;
		lat_bits  <= pt.lat;
		alt_bits  <= pt.alt;
		seg_count <= pt.seg_count;
		seg_first <= pt.seg_first;
		do @(posedge clk); while (!in_ready);
		hit = predict_point(pt, res);
		if (kind == ROW_KEEP) begin
			res.lon   = pt.lon;
			res.lat   = pt.lat;
			res.alt   = pt.alt;
			res.index = idx;
			res.last  = lst;
			kept_q.push_back(res);
		end else if (kind == ROW_PREDICT && hit) begin
			kept_q.push_back(res);
		end
	endtask

	// Hold the sender until every kept point is out and dropped points have cleared.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic program_max(input logic [MAXP_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		max_pts  = value;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (kept_q.size() == 0) begin
					report($sformatf("beat with nothing expected, index %0d", out_index));
				end else begin
					kept_point_t want;
					want = kept_q.pop_front();
					if (out_lon !== want.lon)
						report($sformatf("out_lon %h, want %h", out_lon, want.lon));
					if (out_lat !== want.lat)
						report($sformatf("out_lat %h, want %h", out_lat, want.lat));
					if (out_alt !== want.alt)
						report($sformatf("out_alt %h, want %h", out_alt, want.alt));
					if (out_index !== want.index)
						report($sformatf("out_index %0d, want %0d", out_index, want.index));
					if (seg_last !== want.last)
						report($sformatf("seg_last %b, want %b", seg_last, want.last));
				end
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= 16);
		end
	end

	initial begin
		int          sent;
		int          pick;
		int          n;
		int          part;
		logic [31:0] cnt;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		lon_bits  = '0;
		lat_bits  = '0;
		alt_bits  = '0;
		seg_count = '0;
		seg_first = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		errors    = 0;
		cycles    = 0;
		quiet     = 1'b0;
		max_pts   = MAXP_RESET;
		seg_total = '0;
		seg_pos   = '0;
		seg_kept  = '0;
		thinning  = 1'b0;

		// stray point after reset, empty segment, single point, point past its end, early restart
		plan.push_back(mk(ROW_DROP, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'd7, 0, 0, 0));
		plan.push_back(mk(ROW_DROP, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 32'd0, 1, 0, 0));
		plan.push_back(mk(ROW_KEEP, '1, '1, '1, 32'd1, 1, 32'd0, 1));
		plan.push_back(mk(ROW_DROP, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999, '1, 0, 0, 0));
		plan.push_back(mk(ROW_KEEP, '0, '0, '0, 32'd3, 1, 32'd0, 0));
		plan.push_back(mk(ROW_KEEP, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, '0, 0, 32'd1, 0));
		plan.push_back(mk(ROW_KEEP, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, '1, 1, 32'd0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, '0, 0, 0, 0));
		// tightest thinning
		plan.push_back(mk(ROW_CFG, '0, '0, '0, 32'd2, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'd4, 1, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h0000_0007, 32'h0000_0008, 32'h0000_0009, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h0000_000A, 32'h0000_000B, 32'h0000_000C, 32'd0, 0, 0, 0));
		// a register of zero acts as the floor
		plan.push_back(mk(ROW_CFG, '0, '0, '0, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h8000_0000, 32'd3, 1, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h8000_0001, 32'h7FFF_FFFF, 32'hC000_0000, 32'd3, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 32'd3, 0, 0, 0));
		plan.push_back(mk(ROW_CFG, '0, '0, '0, 32'd65535, 0, 0, 0));
		plan.push_back(mk(ROW_KEEP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0BAD_F00D, 32'd2, 1, 32'd0, 0));
		plan.push_back(mk(ROW_KEEP, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h3C3C_3C3C, 32'd2, 0, 32'd1, 1));
		// register changes mid-segment: thinning stays on, keep test follows the new value
		plan.push_back(mk(ROW_CFG, '0, '0, '0, 32'd3, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 32'd6, 1, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0001, 32'h2000_0001, 32'h3000_0001, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_CFG, '0, '0, '0, 32'd6, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0002, 32'h2000_0002, 32'h3000_0002, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0003, 32'h2000_0003, 32'h3000_0003, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0004, 32'h2000_0004, 32'h3000_0004, 32'd0, 0, 0, 0));
		plan.push_back(mk(ROW_PREDICT, 32'h1000_0005, 32'h2000_0005, 32'h3000_0005, 32'd0, 0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				program_max(plan[i].pt.seg_count[MAXP_W-1:0]);
			else
				send_point(plan[i].pt, plan[i].kind, plan[i].idx, plan[i].lst);
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			quiet = (sent >= 500 && sent < 800);
			if (sent >= 300 && sent < 340)
				drain_results();
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 9))
					0:       program_max(16'($urandom_range(0, 1)));
					1:       program_max(16'hFFFF);
					2:       program_max(16'($urandom));
					default: program_max(16'($urandom_range(2, 12)));
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				n = $urandom_range(1, 40);
				send_point(rand_point(1'b1, n), ROW_PREDICT, 0, 0);
				for (int j = 1; j < n; j++)
					send_point(rand_point(1'b0, $urandom), ROW_PREDICT, 0, 0);
				sent += n;
			end else if (pick < 86) begin
				// points with no segment start: ignored unless a cut-short segment is still open
				repeat ($urandom_range(1, 3))
					send_point(rand_point(1'b0, $urandom), ROW_PREDICT, 0, 0);
			end else if (pick < 91) begin
				send_point(rand_point(1'b1, 32'd0), ROW_PREDICT, 0, 0);
				if ($urandom_range(0, 1))
					send_point(rand_point(1'b0, $urandom), ROW_PREDICT, 0, 0);
				sent++;
			end else if (pick < 97) begin
				// cut short: the next segment start abandons it
				n = $urandom_range(2, 40);
				part = $urandom_range(1, n - 1);
				send_point(rand_point(1'b1, n), ROW_PREDICT, 0, 0);
				for (int j = 1; j < part; j++)
					send_point(rand_point(1'b0, $urandom), ROW_PREDICT, 0, 0);
				sent += part;
			end else begin
				cnt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
				part = $urandom_range(1, 20);
				send_point(rand_point(1'b1, cnt), ROW_PREDICT, 0, 0);
				for (int j = 1; j < part; j++)
					send_point(rand_point(1'b0, $urandom), ROW_PREDICT, 0, 0);
				sent += part;
			end
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
